/* sv/lpp_pkg.sv */
// lidar point projector: shared types, register codes and fixed constants
// no dependencies; imported by the top level
package lpp_pkg;

  // configuration register index
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FOCAL  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_HFOV   = 3'd2,
    REG_SCALE  = 3'd3,
    REG_MINR   = 3'd4
  } cfg_reg_e;

  localparam int CFG_DATA_W = 16;

  // register reset values
  localparam logic [11:0]        FOCAL_RST  = 12'd600;
  localparam logic signed [8:0]  HEIGHT_RST = -9'sd13;
  localparam logic [13:0]        HFOV_RST   = 14'd5461;
  localparam logic [7:0]         SCALE_RST  = 8'd60;
  localparam logic [15:0]        MINR_RST   = 16'd25;

  // sector codes
  localparam logic [1:0] SEC_NONE  = 2'd0;
  localparam logic [1:0] SEC_FRONT = 2'd1;
  localparam logic [1:0] SEC_REAR  = 2'd2;

  // quarter-wave sine polynomial, Q14
  localparam logic [10:0] QS_C1 = 11'd1160;
  localparam logic [13:0] QS_C2 = 14'd10512;
  localparam logic [14:0] QS_C3 = 15'd25736;
  localparam logic [14:0] QUARTER = 15'd16384;

  // quotient bits kept by the camera dividers
  localparam int DIV_QW = 16;

  typedef struct packed {
    logic [15:0]        range;
    logic signed [15:0] angle;
  } lpp_in_t;

  typedef struct packed {
    logic               point_valid;
    logic signed [15:0] map_x;
    logic signed [15:0] map_y;
    logic               map_inside;
    logic [1:0]         sector;
    logic signed [15:0] cam_u;
    logic signed [15:0] cam_v;
    logic               cam_inside;
  } lpp_out_t;

endpackage

/* sv/lpp_div.sv */
// lidar point projector: pipelined restoring divider, one quotient bit per stage
// standalone; quotient magnitude plus an overflow flag when it needs more bits
module lpp_div #(
  parameter int NUM_W = 28,
  parameter int DEN_W = 15,
  parameter int QUO_W = 16
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [QUO_W-1:0] quo_o,
  output logic             ovf_o
);

  localparam int CMP_W = ((NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W) + 1;

  logic [CMP_W-1:0] rem_q [QUO_W];
  logic [DEN_W-1:0] den_q [QUO_W];
  logic [QUO_W-1:0] quo_q [QUO_W+1];
  logic             ovf_q [QUO_W+1];
  logic [CMP_W-1:0] den_top;

  // entry stage: flag quotients that do not fit
  assign den_top = CMP_W'(den_i) << QUO_W;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= CMP_W'(num_i);
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      ovf_q[0] <= (CMP_W'(num_i) >= den_top);
    end
  end

  // one compare and subtract per stage, msb first
  for (genvar k = 1; k <= QUO_W; k++) begin : g_step
    logic [CMP_W-1:0] dsh;
    logic             ge;

    assign dsh = CMP_W'(den_q[k-1]) << (QUO_W - k);
    assign ge  = (rem_q[k-1] >= dsh);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[k] <= {quo_q[k-1][QUO_W-2:0], ge};
        ovf_q[k] <= ovf_q[k-1];
      end
    end

    if (k < QUO_W) begin : g_keep
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k] <= ge ? (rem_q[k-1] - dsh) : rem_q[k-1];
          den_q[k] <= den_q[k-1];
        end
      end
    end
  end

  assign quo_o = quo_q[QUO_W];
  assign ovf_o = ovf_q[QUO_W];

endmodule

/* sv/lidar_point_projector.sv */
// lidar point projector top level: polar return to top-view map and camera pixel
// depends on lpp_pkg and lpp_div
//
// Usage:
//  in channel: one word per lidar return (range in 1/256 m, binary angle).
//  A word moves when in_valid_i is high and in_stall_o low.
//  out channel: one result word per input word, same order; moves when
//  out_valid_o is high and out_stall_i low.
//  cfg channel: cfg_ready_o is always high; a write lands at the edge where
//  cfg_valid_i is high. Unknown indexes are dropped. Write only while idle.
//  Throughput: one word per cycle while the pipe is not held. The pipe has nine
//  arithmetic stages (sine polynomial, products, map and numerator sums) and the
//  17-stage pipelined dividers for camera u and v.
//  A two-entry output queue follows the pipe, so new words are still taken
//  while up to two results wait. When the queue is full and the receiver
//  stalls, the whole pipe holds and in_stall_o rises.
//  Reset clears the pipe valid bits and the queue and loads the register
//  defaults (focal 600, height -13, half fov 5461, scale 60, min range 25).
module lidar_point_projector #(
  parameter int MAP_DIM      = 600,
  parameter int IMAGE_WIDTH  = 640,
  parameter int IMAGE_HEIGHT = 480
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  lpp_pkg::lpp_in_t                    in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output lpp_pkg::lpp_out_t                   out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [lpp_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [lpp_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  import lpp_pkg::*;

  localparam int DIV_LAT = DIV_QW + 1;
  localparam int NUM_ST  = 9 + DIV_LAT;

  localparam logic [11:0] HALF_W = 12'(IMAGE_WIDTH / 2);
  localparam logic [11:0] HALF_H = 12'(IMAGE_HEIGHT / 2);
  localparam logic [19:0] CENTER = 20'(MAP_DIM / 2);
  localparam logic [19:0] MAP_LIM = 20'(MAP_DIM);
  localparam logic [15:0] IMG_W_LIM = 16'(IMAGE_WIDTH);
  localparam logic [15:0] IMG_H_LIM = 16'(IMAGE_HEIGHT);

  typedef struct packed {
    logic        pv;
    logic [1:0]  sector;
    logic [15:0] map_x;
    logic [15:0] map_y;
    logic        map_in;
    logic        neg_u;
    logic        neg_v;
    logic        zok;
  } side_t;

  // saturate a 20-bit signed value to 16 bits
  function automatic logic [15:0] sat16(logic [19:0] v);
    logic [15:0] r;
    if (!v[19] && (v[18:15] != 4'd0)) begin
      r = 16'h7FFF;
    end else if (v[19] && (v[18:15] != 4'hF)) begin
      r = 16'h8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // signed camera coordinate from quotient magnitude
  function automatic logic [15:0] cam_coord(logic neg, logic ovf, logic [15:0] q);
    logic [15:0] r;
    if (neg) begin
      r = (ovf || (q > 16'd32768)) ? 16'h8000 : (16'd0 - q);
    end else begin
      r = (ovf || q[15]) ? 16'h7FFF : q;
    end
    return r;
  endfunction

  // configuration registers
  logic [11:0]        focal_q;
  logic signed [8:0]  height_q;
  logic [13:0]        hfov_q;
  logic [7:0]         scale_q;
  logic [15:0]        minr_q;
  logic signed [21:0] fh_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_q  <= FOCAL_RST;
      height_q <= HEIGHT_RST;
      hfov_q   <= HFOV_RST;
      scale_q  <= SCALE_RST;
      minr_q   <= MINR_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_FOCAL:  focal_q  <= cfg_data_i[11:0];
        REG_HEIGHT: height_q <= $signed(cfg_data_i[8:0]);
        REG_HFOV:   hfov_q   <= cfg_data_i[13:0];
        REG_SCALE:  scale_q  <= cfg_data_i[7:0];
        REG_MINR:   minr_q   <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // focal times height, follows the registers
  always_ff @(posedge clk_i) begin
    fh_q <= $signed({1'b0, focal_q}) * height_q;
  end

  // flow control
  logic              adv;
  logic [1:0]        cnt_q;
  logic [NUM_ST-1:0] vld_q;

  assign adv        = (cnt_q != 2'd2) || !out_stall_i;
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NUM_ST-2:0], in_valid_i};
    end
  end

  // stage 1: validity, sector, quadrant folding
  logic [15:0] a;
  logic [16:0] abs_f, abs_r;
  logic [15:0] ar;
  logic [1:0]  qc;
  logic [1:0]  sec_d;
  logic [14:0] zs_d, zc_d;

  assign a     = in_data_i.angle;
  assign ar    = {~a[15], a[14:0]};
  assign abs_f = a[15] ? (17'd0 - {a[15], a}) : {1'b0, a};
  assign abs_r = ar[15] ? (17'd0 - {ar[15], ar}) : {1'b0, ar};
  assign qc    = a[15:14] + 2'd1;
  assign zs_d  = a[14] ? (QUARTER - {1'b0, a[13:0]}) : {1'b0, a[13:0]};
  assign zc_d  = qc[0] ? (QUARTER - {1'b0, a[13:0]}) : {1'b0, a[13:0]};

  always_comb begin
    if (abs_f <= {3'b0, hfov_q}) begin
      sec_d = SEC_FRONT;
    end else if (abs_r <= {3'b0, hfov_q}) begin
      sec_d = SEC_REAR;
    end else begin
      sec_d = SEC_NONE;
    end
  end

  logic        s1_pv_q;
  logic [1:0]  s1_sec_q;
  logic [15:0] s1_range_q;
  logic [14:0] s1_zs_q, s1_zc_q;
  logic        s1_ns_q, s1_nc_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_pv_q    <= (in_data_i.range > minr_q);
      s1_sec_q   <= sec_d;
      s1_range_q <= in_data_i.range;
      s1_zs_q    <= zs_d;
      s1_zc_q    <= zc_d;
      s1_ns_q    <= a[15];
      s1_nc_q    <= qc[1];
    end
  end

  // stage 2: z squared, range times scale
  logic [29:0] zz_s, zz_c;

  assign zz_s = 30'(s1_zs_q) * 30'(s1_zs_q);
  assign zz_c = 30'(s1_zc_q) * 30'(s1_zc_q);

  logic        s2_pv_q;
  logic [1:0]  s2_sec_q;
  logic [15:0] s2_range_q;
  logic [23:0] s2_k_q;
  logic [14:0] s2_zs_q, s2_zc_q, s2_z2s_q, s2_z2c_q;
  logic        s2_ns_q, s2_nc_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_pv_q    <= s1_pv_q;
      s2_sec_q   <= s1_sec_q;
      s2_range_q <= s1_range_q;
      s2_k_q     <= 24'(s1_range_q) * 24'(scale_q);
      s2_zs_q    <= s1_zs_q;
      s2_zc_q    <= s1_zc_q;
      s2_z2s_q   <= zz_s[28:14];
      s2_z2c_q   <= zz_c[28:14];
      s2_ns_q    <= s1_ns_q;
      s2_nc_q    <= s1_nc_q;
    end
  end

  // stage 3: first polynomial term
  logic [25:0] p3_s, p3_c;

  assign p3_s = 26'(QS_C1) * 26'(s2_z2s_q);
  assign p3_c = 26'(QS_C1) * 26'(s2_z2c_q);

  logic        s3_pv_q;
  logic [1:0]  s3_sec_q;
  logic [15:0] s3_range_q;
  logic [23:0] s3_k_q;
  logic [14:0] s3_zs_q, s3_zc_q, s3_z2s_q, s3_z2c_q;
  logic [13:0] s3_ts_q, s3_tc_q;
  logic        s3_ns_q, s3_nc_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_pv_q    <= s2_pv_q;
      s3_sec_q   <= s2_sec_q;
      s3_range_q <= s2_range_q;
      s3_k_q     <= s2_k_q;
      s3_zs_q    <= s2_zs_q;
      s3_zc_q    <= s2_zc_q;
      s3_z2s_q   <= s2_z2s_q;
      s3_z2c_q   <= s2_z2c_q;
      s3_ts_q    <= QS_C2 - 14'(p3_s[25:14]);
      s3_tc_q    <= QS_C2 - 14'(p3_c[25:14]);
      s3_ns_q    <= s2_ns_q;
      s3_nc_q    <= s2_nc_q;
    end
  end

  // stage 4: second polynomial term
  logic [28:0] p4_s, p4_c;

  assign p4_s = 29'(s3_z2s_q) * 29'(s3_ts_q);
  assign p4_c = 29'(s3_z2c_q) * 29'(s3_tc_q);

  logic        s4_pv_q;
  logic [1:0]  s4_sec_q;
  logic [15:0] s4_range_q;
  logic [23:0] s4_k_q;
  logic [14:0] s4_zs_q, s4_zc_q, s4_ts_q, s4_tc_q;
  logic        s4_ns_q, s4_nc_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_pv_q    <= s3_pv_q;
      s4_sec_q   <= s3_sec_q;
      s4_range_q <= s3_range_q;
      s4_k_q     <= s3_k_q;
      s4_zs_q    <= s3_zs_q;
      s4_zc_q    <= s3_zc_q;
      s4_ts_q    <= QS_C3 - p4_s[28:14];
      s4_tc_q    <= QS_C3 - p4_c[28:14];
      s4_ns_q    <= s3_ns_q;
      s4_nc_q    <= s3_nc_q;
    end
  end

  // stage 5: final sine and cosine with quadrant sign
  logic [29:0] p5_s, p5_c;
  logic [15:0] mag_s, mag_c;

  assign p5_s  = 30'(s4_zs_q) * 30'(s4_ts_q);
  assign p5_c  = 30'(s4_zc_q) * 30'(s4_tc_q);
  assign mag_s = {1'b0, p5_s[28:14]};
  assign mag_c = {1'b0, p5_c[28:14]};

  logic        s5_pv_q;
  logic [1:0]  s5_sec_q;
  logic [15:0] s5_range_q;
  logic [23:0] s5_k_q;
  logic [15:0] s5_sin_q, s5_cos_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s5_pv_q    <= s4_pv_q;
      s5_sec_q   <= s4_sec_q;
      s5_range_q <= s4_range_q;
      s5_k_q     <= s4_k_q;
      s5_sin_q   <= s4_ns_q ? (16'd0 - mag_s) : mag_s;
      s5_cos_q   <= s4_nc_q ? (16'd0 - mag_c) : mag_c;
    end
  end

  // stage 6: map products, camera numerator terms and depth
  logic [15:0]        sr, cr;
  logic [14:0]        crm;
  logic signed [40:0] mxp_d, myp_d;
  logic signed [28:0] fs_d;
  logic [30:0]        dp_d;

  assign sr    = (s5_sec_q == SEC_REAR) ? (16'd0 - s5_sin_q) : s5_sin_q;
  assign cr    = (s5_sec_q == SEC_REAR) ? (16'd0 - s5_cos_q) : s5_cos_q;
  assign crm   = cr[14:0];
  assign mxp_d = $signed({1'b0, s5_k_q}) * $signed(s5_sin_q);
  assign myp_d = $signed({1'b0, s5_k_q}) * $signed(s5_cos_q);
  assign fs_d  = $signed({1'b0, focal_q}) * $signed(sr);
  assign dp_d  = 31'(s5_range_q) * 31'(crm);

  logic        s6_pv_q;
  logic [1:0]  s6_sec_q;
  logic [40:0] s6_mxp_q, s6_myp_q;
  logic [28:0] s6_fs_q;
  logic [26:0] s6_cw_q;
  logic [29:0] s6_depth_q;
  logic [14:0] s6_crm_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s6_pv_q    <= s5_pv_q;
      s6_sec_q   <= s5_sec_q;
      s6_mxp_q   <= mxp_d;
      s6_myp_q   <= myp_d;
      s6_fs_q    <= fs_d;
      s6_cw_q    <= 27'(crm) * 27'(HALF_W);
      s6_depth_q <= dp_d[29:0];
      s6_crm_q   <= crm;
    end
  end

  // stage 7: map offsets truncated toward zero, u numerator
  logic [40:0] adj_x, adj_y;

  assign adj_x = s6_mxp_q[40] ? (s6_mxp_q + 41'h3FFFFF) : s6_mxp_q;
  assign adj_y = s6_myp_q[40] ? (s6_myp_q + 41'h3FFFFF) : s6_myp_q;

  logic        s7_pv_q;
  logic [1:0]  s7_sec_q;
  logic [18:0] s7_mqx_q, s7_mqy_q;
  logic [28:0] s7_nu_q;
  logic [41:0] s7_dh_q;
  logic [29:0] s7_depth_q;
  logic [14:0] s7_crm_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s7_pv_q    <= s6_pv_q;
      s7_sec_q   <= s6_sec_q;
      s7_mqx_q   <= adj_x[40:22];
      s7_mqy_q   <= adj_y[40:22];
      s7_nu_q    <= s6_fs_q + {2'b0, s6_cw_q};
      s7_dh_q    <= 42'(s6_depth_q) * 42'(HALF_H);
      s7_depth_q <= s6_depth_q;
      s7_crm_q   <= s6_crm_q;
    end
  end

  // stage 8: map coordinates, v numerator
  logic [19:0] mx20, my20;

  assign mx20 = CENTER + {s7_mqx_q[18], s7_mqx_q};
  assign my20 = CENTER - {s7_mqy_q[18], s7_mqy_q};

  logic        s8_pv_q;
  logic [1:0]  s8_sec_q;
  logic [15:0] s8_mx_q, s8_my_q;
  logic        s8_min_q;
  logic [28:0] s8_nu_q;
  logic [43:0] s8_nv_q;
  logic [29:0] s8_depth_q;
  logic [14:0] s8_crm_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s8_pv_q    <= s7_pv_q;
      s8_sec_q   <= s7_sec_q;
      s8_mx_q    <= sat16(mx20);
      s8_my_q    <= sat16(my20);
      s8_min_q   <= !mx20[19] && (mx20 < MAP_LIM) && !my20[19] && (my20 < MAP_LIM);
      s8_nu_q    <= s7_nu_q;
      s8_nv_q    <= {{8{fh_q[21]}}, fh_q, 14'b0} + {2'b0, s7_dh_q};
      s8_depth_q <= s7_depth_q;
      s8_crm_q   <= s7_crm_q;
    end
  end

  // stage 9: magnitudes and depth test
  logic [28:0] nu_abs;
  logic [43:0] nv_abs;

  assign nu_abs = s8_nu_q[28] ? (29'd0 - s8_nu_q) : s8_nu_q;
  assign nv_abs = s8_nv_q[43] ? (44'd0 - s8_nv_q) : s8_nv_q;

  logic [27:0] s9_nu_q;
  logic [42:0] s9_nv_q;
  logic [29:0] s9_depth_q;
  logic [14:0] s9_crm_q;
  side_t       side_q [DIV_LAT+1];
  side_t       side_d;

  always_comb begin
    side_d.pv     = s8_pv_q;
    side_d.sector = s8_sec_q;
    side_d.map_x  = s8_mx_q;
    side_d.map_y  = s8_my_q;
    side_d.map_in = s8_min_q;
    side_d.neg_u  = s8_nu_q[28];
    side_d.neg_v  = s8_nv_q[43];
    side_d.zok    = (s8_depth_q > {minr_q, 14'b0});
  end

  // side data rides along stage 9 and every divider stage
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s9_nu_q    <= nu_abs[27:0];
      s9_nv_q    <= nv_abs[42:0];
      s9_depth_q <= s8_depth_q;
      s9_crm_q   <= s8_crm_q;
      side_q[0]  <= side_d;
      for (int i = 1; i < DIV_LAT + 1; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  // stages 10 to 26: camera dividers
  logic [DIV_QW-1:0] qu, qv;
  logic              ovf_u, ovf_v;

  lpp_div #(
    .NUM_W (28),
    .DEN_W (15),
    .QUO_W (DIV_QW)
  ) u_div_u (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (s9_nu_q),
    .den_i (s9_crm_q),
    .quo_o (qu),
    .ovf_o (ovf_u)
  );

  lpp_div #(
    .NUM_W (43),
    .DEN_W (30),
    .QUO_W (DIV_QW)
  ) u_div_v (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (s9_nv_q),
    .den_i (s9_depth_q),
    .quo_o (qv),
    .ovf_o (ovf_v)
  );

  // result word assembly
  side_t    sd;
  lpp_out_t res;
  logic     in_u, in_v;
  logic     cam_on;

  assign sd     = side_q[DIV_LAT];
  assign cam_on = sd.pv && (sd.sector != SEC_NONE);
  assign in_u   = !ovf_u && (!sd.neg_u || (qu == 16'd0)) && (qu < IMG_W_LIM);
  assign in_v   = !ovf_v && (!sd.neg_v || (qv == 16'd0)) && (qv < IMG_H_LIM);

  always_comb begin
    res             = '0;
    res.point_valid = sd.pv;
    if (sd.pv) begin
      res.map_x      = sd.map_x;
      res.map_y      = sd.map_y;
      res.map_inside = sd.map_in;
      res.sector     = sd.sector;
    end
    if (cam_on) begin
      res.cam_u      = cam_coord(sd.neg_u, ovf_u, qu);
      res.cam_v      = cam_coord(sd.neg_v, ovf_v, qv);
      res.cam_inside = sd.zok && in_u && in_v;
    end
  end

  // two-entry output queue
  lpp_out_t mem_q [2];
  logic     wr_ptr_q, rd_ptr_q;
  logic     enq, deq;

  assign enq = adv && vld_q[NUM_ST-1];
  assign deq = (cnt_q != 2'd0) && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      if (enq) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (deq) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, enq} - {1'b0, deq};
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) begin
      mem_q[wr_ptr_q] <= res;
    end
  end

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = mem_q[rd_ptr_q];

endmodule
